### src/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and functions of the line frame deframer
// frame record passed from the front part to the back part, crc step
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int unsigned MaxLines  = 8;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0]  position;
    logic [1:0]  length_class;
    logic        first_side;
    logic        meta_last;
    logic        crc_ok;
    logic [15:0] first_seen_tick;
  } frame_t;

  // one byte of the reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/line_frame_deframer_crc16_top.sv
// ----------------------------------------------------------------------------
// line_frame_deframer_crc16_top: line frame deframer with crc-16 check
//
// channel   dir  handshake               payload
// s_axis    in   s_tvalid / s_tready     frame_byte, now_tick
// m_axis    out  m_tvalid / m_tready     one result per five-byte frame
// apb       in   psel / penable / pready gap_limit at addresses 0 to 3
//
// one byte item a cycle unless queue is full; crc runs bytewise in lfd_front
// a result is queued with its fifth byte, then loaded into the output register
// a two-entry queue and the output register part input and output stalls
// synchronous active-high reset; no clearing pass
// ----------------------------------------------------------------------------
module line_frame_deframer_crc16_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // frame_byte[7:0], now_tick[23:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  // line_position[7:0], length_class[9:8], first_side[10], last_line[11],
  // crc_ok[12], line_number[16:13], first_seen_tick[32:17], zero[39:33]
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]      gap_limit;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  lfd_pkg::frame_t q_in;
  lfd_pkg::frame_t q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'h0, gap_limit} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= 8'd2;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      gap_limit <= pwdata[7:0];
    end
  end

  lfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .gap_limit  (gap_limit),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .frame_byte (s_tdata[7:0]),
    .now_tick   (s_tdata[23:8]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  lfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  lfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

endmodule

### src/lfd_front.sv
// ----------------------------------------------------------------------------
// lfd_front: byte intake and frame assembly
// tracks tick gaps, collects five bytes, runs the crc and checks a frame
// ----------------------------------------------------------------------------
module lfd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           gap_limit,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           frame_byte,
  input  logic [15:0]          now_tick,
  input  logic                 q_full,
  output logic                 q_push,
  output lfd_pkg::frame_t      q_data
);

  logic [2:0]  byte_count;
  logic [2:0]  byte_count_next;
  logic [15:0] last_byte_tick;
  logic [15:0] first_tick;
  logic [15:0] first_tick_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  byte_buffer [4];
  logic [15:0] gap;
  logic [2:0]  count_eff;
  logic [15:0] rx_crc;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    gap             = now_tick - last_byte_tick;
    count_eff       = (gap > {8'h00, gap_limit}) ? 3'd0 : byte_count;
    first_tick_next = (first_tick == 16'h0000) ? now_tick : first_tick;
    byte_count_next = (count_eff < 3'd4) ? count_eff + 3'd1 : 3'd0;
    if (count_eff == 3'd0) begin
      crc_next = lfd_pkg::crc_byte(lfd_pkg::CrcInit, frame_byte);
    end else if (count_eff == 3'd1) begin
      crc_next = lfd_pkg::crc_byte(crc, frame_byte);
    end else begin
      crc_next = crc;
    end
    rx_crc = {8'h00, byte_buffer[2]} | {1'b0, byte_buffer[3], 7'b0}
           | {frame_byte[1:0], 14'b0};
  end

  always_comb begin
    q_push                  = take && (count_eff == 3'd4);
    q_data.position         = byte_buffer[1];
    q_data.length_class     = byte_buffer[0][5:4];
    q_data.first_side       = byte_buffer[0][6];
    q_data.meta_last        = byte_buffer[0][0];
    q_data.crc_ok           = (crc == rx_crc);
    q_data.first_seen_tick  = first_tick_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= 3'd0;
      last_byte_tick <= 16'h0000;
      first_tick     <= 16'h0000;
    end else if (take) begin
      byte_count     <= byte_count_next;
      last_byte_tick <= now_tick;
      first_tick     <= first_tick_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crc <= crc_next;
      if (count_eff < 3'd4) begin
        byte_buffer[count_eff[1:0]] <= frame_byte;
      end
    end
  end

endmodule

### src/lfd_queue.sv
// ----------------------------------------------------------------------------
// lfd_queue: short frame record queue
// two-entry fifo between the front and back parts
// ----------------------------------------------------------------------------
module lfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lfd_pkg::frame_t      push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output lfd_pkg::frame_t      pop_data
);

  localparam int unsigned PtrW = $clog2(lfd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(lfd_pkg::QueueDepth + 1);

  lfd_pkg::frame_t entries [lfd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full      = (fill == CntW'(lfd_pkg::QueueDepth));
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(lfd_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(lfd_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### src/lfd_back.sv
// ----------------------------------------------------------------------------
// lfd_back: frame result stage
// numbers good lines with a saturating count and holds the result register
// ----------------------------------------------------------------------------
module lfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  lfd_pkg::frame_t      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [39:0]          out_data
);

  logic [3:0]  good_lines;
  logic [3:0]  good_lines_next;
  logic [3:0]  line_number;
  logic [39:0] result_next;

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    line_number     = q_data.crc_ok ? good_lines : 4'd0;
    good_lines_next = good_lines;
    if (q_data.crc_ok && (good_lines < 4'(lfd_pkg::MaxLines))) begin
      good_lines_next = good_lines + 4'd1;
    end
    result_next = {7'b0, q_data.first_seen_tick, line_number, q_data.crc_ok,
                   q_data.crc_ok & q_data.meta_last, q_data.first_side,
                   q_data.length_class, q_data.position};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      good_lines <= 4'd0;
    end else begin
      if (q_pop) begin
        out_valid  <= 1'b1;
        good_lines <= good_lines_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= result_next;
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: line frame deframer with crc-16 check
// byte items with tick stamps go in through the slave stream, frame results
// come out of the master stream and are checked field by field against a
// predictor kept in step with every item and register write taken
// a short directed part is followed by random phases at several gap limits
// and idle patterns, with the sender paused until all results are in
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] GapLimitAddr  = 3'd0;
  localparam logic [7:0] GapLimitReset = 8'd2;
  localparam int         DrainCycles   = 8;
  localparam int         StallLimit    = 2000;

  typedef enum int {FrameGood, FrameCrcFlip, FrameCrcNoise} frame_kind_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] first_seen_tick;
    logic [3:0]  line_number;
    logic        crc_ok;
    logic        last_line;
    logic        first_side;
    logic [1:0]  length_class;
    logic [7:0]  line_position;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // frame_byte[7:0], now_tick[23:8]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // line_position[7:0], length_class[9:8], first_side[10], last_line[11],
  // crc_ok[12], line_number[16:13], first_seen_tick[32:17], zero[39:33]
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_frame_deframer_crc16_top dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  logic [23:0]   pending_bytes[$];
  frame_result_t frames_due[$];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            fault_count = 0;
  bit            in_fire = 1'b0;

  // predictor state
  logic [7:0]  gap_limit_q;
  logic [7:0]  held_bytes[4];
  logic [2:0]  held_count;
  logic [15:0] prev_tick;
  logic [15:0] first_tick_q;
  logic [3:0]  good_count;

  // stimulus-side copy of the frame alignment
  logic [7:0]  gen_limit = GapLimitReset;
  logic [2:0]  gen_pos = '0;
  logic [15:0] gen_last = '0;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ lfd_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit deframe_step(input logic [7:0] b, input logic [15:0] tick,
                                      output frame_result_t r);
    logic [15:0] gap;
    logic [15:0] crc;
    logic [15:0] rx;
    bit          ok;
    r = '0;
    if (first_tick_q == 16'd0) first_tick_q = tick;
    gap = tick - prev_tick;
    if (gap > {8'h00, gap_limit_q}) held_count = '0;
    prev_tick = tick;
    if (held_count < 3'd4) begin
      held_bytes[held_count[1:0]] = b;
      held_count = held_count + 3'd1;
      return 1'b0;
    end
    held_count = '0;
    crc = crc16_fold(crc16_fold(lfd_pkg::CrcInit, held_bytes[0]), held_bytes[1]);
    rx = 16'({24'h0, held_bytes[2]} | ({24'h0, held_bytes[3]} << 7) | ({24'h0, b} << 14));
    ok = (crc == rx);
    r.line_position   = held_bytes[1];
    r.length_class    = held_bytes[0][5:4];
    r.first_side      = held_bytes[0][6];
    r.last_line       = ok & held_bytes[0][0];
    r.crc_ok          = ok;
    r.line_number     = ok ? good_count : 4'd0;
    r.first_seen_tick = first_tick_q;
    if (ok && good_count < lfd_pkg::MaxLines) good_count = good_count + 4'd1;
    return 1'b1;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endfunction

  // predictor and result checker
  always @(posedge clk) begin : predict_and_check
    frame_result_t want;
    frame_result_t got;
    frame_result_t pred;
    in_fire = s_tvalid && s_tready;
    if (rst) begin
      gap_limit_q  = GapLimitReset;
      held_bytes   = '{default: 8'h00};
      held_count   = '0;
      prev_tick    = '0;
      first_tick_q = '0;
      good_count   = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == GapLimitAddr) begin
        gap_limit_q = pwdata[7:0];
      end
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          $error("frame result %h with none expected", m_tdata);
          fault_count++;
        end else begin
          want = frames_due.pop_front();
          got  = m_tdata;
          check_field("line_position", want.line_position, got.line_position);
          check_field("length_class", want.length_class, got.length_class);
          check_field("first_side", want.first_side, got.first_side);
          check_field("last_line", want.last_line, got.last_line);
          check_field("crc_ok", want.crc_ok, got.crc_ok);
          check_field("line_number", want.line_number, got.line_number);
          check_field("first_seen_tick", want.first_seen_tick, got.first_seen_tick);
        end
      end
      if (in_fire && deframe_step(s_tdata[7:0], s_tdata[23:8], pred)) begin
        frames_due.push_back(pred);
      end
    end
  end

  // byte sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tdata  <= pending_bytes.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic [15:0] tick);
    logic [15:0] gap;
    gap = tick - gen_last;
    if (gap > {8'h00, gen_limit}) gen_pos = '0;
    gen_last = tick;
    gen_pos = (gen_pos == 3'd4) ? 3'd0 : gen_pos + 3'd1;
    pending_bytes.push_back({tick, b});
  endfunction

  function automatic logic [15:0] next_tick(input bit jump);
    if (jump) return gen_last + 16'($urandom_range(int'(gen_limit) + 1, 65535));
    return gen_last + 16'($urandom_range(0, int'(gen_limit)));
  endfunction

  // five frame bytes, byte i at [8*i +: 8]
  function automatic logic [39:0] build_frame(input logic [7:0] meta, input logic [7:0] pos,
                                              input frame_kind_t kind);
    logic [15:0] v;
    logic [7:0]  b4_hi;
    v = crc16_fold(crc16_fold(lfd_pkg::CrcInit, meta), pos);
    b4_hi = 8'($urandom);
    case (kind)
      FrameCrcFlip: begin
        v = v ^ (16'h0001 << $urandom_range(0, 15));
      end
      FrameCrcNoise: begin
        return {8'($urandom), 8'($urandom), 8'($urandom), pos, meta};
      end
      default: begin
      end
    endcase
    return {b4_hi[7:2], v[15:14], v[14:7], v[7:0], pos, meta};
  endfunction

  function automatic void send_frame(input frame_kind_t kind, input int nbytes);
    logic [39:0] fb;
    logic [15:0] tick;
    fb = build_frame(8'($urandom), 8'($urandom), kind);
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0) tick = next_tick(gen_pos != 3'd0 || $urandom_range(0, 3) == 0);
      else tick = next_tick(1'b0);
      push_byte(fb[8*i +: 8], tick);
    end
  endfunction

  function automatic void fill_phase(input int n);
    int r;
    while (pending_bytes.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_frame(FrameGood, 5);
      else if (r < 73) send_frame(FrameCrcFlip, 5);
      else if (r < 80) send_frame(FrameCrcNoise, 5);
      else if (r < 90) send_frame(FrameGood, $urandom_range(1, 4));
      else push_byte(8'($urandom), next_tick($urandom_range(0, 1)));
    end
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_tvalid || frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_gap_limit(input logic [7:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= GapLimitAddr;
    pwdata  <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gen_limit = v;
  endtask

  task automatic push_frame_at(input logic [39:0] fb, input logic [15:0] t0,
                               input logic [15:0] t1, input logic [15:0] t2,
                               input logic [15:0] t3, input logic [15:0] t4);
    push_byte(fb[7:0], t0);
    push_byte(fb[15:8], t1);
    push_byte(fb[23:16], t2);
    push_byte(fb[31:24], t3);
    push_byte(fb[39:32], t4);
  endtask

  initial begin
    logic [39:0] fb;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    recv_idle_pct = 54;

    // first bytes at tick zero, all-ones meta and position bytes, gaps at the limit
    push_frame_at(build_frame(8'hFF, 8'hFF, FrameGood), 16'd0, 16'd0, 16'd1, 16'd3, 16'd3);
    push_frame_at(build_frame(8'h00, 8'h00, FrameGood), 16'd5, 16'd7, 16'd7, 16'd7, 16'd9);
    // bad crc
    push_frame_at(build_frame(8'h10, 8'h80, FrameCrcFlip), 16'd10, 16'd11, 16'd12,
                  16'd13, 16'd14);
    // partial frame cut by a gap, then a frame across the tick wrap
    fb = build_frame(8'h41, 8'h01, FrameGood);
    push_byte(fb[7:0], 16'd16);
    push_byte(fb[15:8], 16'd17);
    push_frame_at(build_frame(8'h61, 8'h7E, FrameGood), 16'hFFFE, 16'hFFFF, 16'd0,
                  16'd1, 16'd1);
    wait_drained();

    write_gap_limit(8'd0);
    fill_phase(650);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 20;
    write_gap_limit(8'd255);
    fill_phase(650);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gap_limit(8'($urandom_range(1, 254)));
    fill_phase(630);
    wait_drained();

    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
src/lfd_pkg.sv
src/lfd_front.sv
src/lfd_queue.sv
src/lfd_back.sv
src/line_frame_deframer_crc16_top.sv
dv/testbench.sv
